@@ hw/rtl/complex_arithmetic_unit_defines.svh @@
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// check a condition in the same cycle
`define CAU_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check a condition in the cycle after the antecedent
`define CAU_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/cau_pkg.sv @@
`timescale 1ns / 1ps
package cau_pkg;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DATA_W = 32;
   localparam int PROD_W = 64;
   localparam int SUM_W = PROD_W + 1;
   localparam int SAT_W = SUM_W + 1;
   localparam int QUOT_W = 32;
   localparam int REM_W = PROD_W + 1;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_SUB = 2'd1;
   localparam logic [1:0] FUNC_MUL = 2'd2;
   localparam logic [1:0] FUNC_DIV = 2'd3;

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic [1:0] func_type;
   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic     ovf;
      data_type val;
   } sat_type;

   typedef struct packed {
      func_type func;
      logic     equal;
      logic     dz;
      logic     neg_re;
      logic     neg_im;
      logic     pre_ovf;
      data_type pre_re;
      data_type pre_im;
   } meta_type;

   function automatic sat_type sat_fn(input logic signed [SAT_W-1:0] v);
      sat_type r;
      logic [SAT_W-DATA_W:0] hi;
      hi = v[SAT_W-1:DATA_W-1];
      if ((&hi) || !(|hi)) begin
         r.ovf = 1'b0;
         r.val = v[DATA_W-1:0];
      end else begin
         r.ovf = 1'b1;
         r.val = v[SAT_W-1] ? DATA_MIN : DATA_MAX;
      end
      return r;
   endfunction
endpackage

@@ hw/rtl/cau_if.sv @@
`timescale 1ns / 1ps
interface cau_req_if;
   logic                valid;
   logic                ready;
   cau_pkg::func_type   func;
   cau_pkg::data_type   a_re;
   cau_pkg::data_type   a_im;
   cau_pkg::data_type   b_re;
   cau_pkg::data_type   b_im;
   modport source(output valid, func, a_re, a_im, b_re, b_im, input ready);
   modport sink(input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
   logic                valid;
   logic                ready;
   cau_pkg::data_type   res_re;
   cau_pkg::data_type   res_im;
   logic                overflow;
   logic                div_by_zero;
   logic                equal;
   modport source(output valid, res_re, res_im, overflow, div_by_zero, equal, input ready);
   modport sink(input valid, res_re, res_im, overflow, div_by_zero, equal, output ready);
endinterface

@@ hw/rtl/cau_prod.sv @@
`timescale 1ns / 1ps
module cau_prod #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  cau_pkg::func_type          in_func,
   input  cau_pkg::data_type          in_a_re,
   input  cau_pkg::data_type          in_a_im,
   input  cau_pkg::data_type          in_b_re,
   input  cau_pkg::data_type          in_b_im,
   output logic                       out_valid,
   output cau_pkg::meta_type          out_meta,
   output logic [cau_pkg::PROD_W-1:0] out_mag_re,
   output logic [cau_pkg::PROD_W-1:0] out_mag_im,
   output logic [cau_pkg::PROD_W-1:0] out_den
);
   import cau_pkg::*;

   logic [2:0]                valid_ff;
   logic [2:0]                valid_in;
   func_type                  func1_ff;
   logic                      eq1_ff, dz1_ff;
   sat_type                   as_re1_ff, as_im1_ff, as_re1_in, as_im1_in;
   logic signed [PROD_W-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, d_r_ff, d_i_ff;
   logic signed [DATA_W:0]    sum_re, sum_im;

   func_type                  func2_ff;
   logic                      eq2_ff, dz2_ff;
   sat_type                   as_re2_ff, as_im2_ff;
   logic signed [SUM_W-1:0]   s_mre_ff, s_mim_ff, s_dre_ff, s_dim_ff;
   logic [PROD_W-1:0]         den2_ff;

   meta_type                  meta3_ff, meta3_in;
   logic [PROD_W-1:0]         mag_re3_ff, mag_im3_ff, mag_re3_in, mag_im3_in, den3_ff;
   logic signed [SUM_W-1:0]   sh_re, sh_im, neg_dre, neg_dim;
   sat_type                   mul_re, mul_im;

   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      if (in_func == FUNC_SUB) begin
         sum_re = (DATA_W+1)'(in_a_re) - (DATA_W+1)'(in_b_re);
         sum_im = (DATA_W+1)'(in_a_im) - (DATA_W+1)'(in_b_im);
      end else begin
         sum_re = (DATA_W+1)'(in_a_re) + (DATA_W+1)'(in_b_re);
         sum_im = (DATA_W+1)'(in_a_im) + (DATA_W+1)'(in_b_im);
      end
      as_re1_in = sat_fn(SAT_W'(sum_re));
      as_im1_in = sat_fn(SAT_W'(sum_im));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         func1_ff  <= in_func;
         eq1_ff    <= (in_a_re == in_b_re) && (in_a_im == in_b_im);
         dz1_ff    <= (in_func == FUNC_DIV) && (in_b_re == '0) && (in_b_im == '0);
         as_re1_ff <= as_re1_in;
         as_im1_ff <= as_im1_in;
         p_rr_ff   <= PROD_W'(in_a_re) * PROD_W'(in_b_re);
         p_ii_ff   <= PROD_W'(in_a_im) * PROD_W'(in_b_im);
         p_ri_ff   <= PROD_W'(in_a_re) * PROD_W'(in_b_im);
         p_ir_ff   <= PROD_W'(in_a_im) * PROD_W'(in_b_re);
         d_r_ff    <= PROD_W'(in_b_re) * PROD_W'(in_b_re);
         d_i_ff    <= PROD_W'(in_b_im) * PROD_W'(in_b_im);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         func2_ff  <= func1_ff;
         eq2_ff    <= eq1_ff;
         dz2_ff    <= dz1_ff;
         as_re2_ff <= as_re1_ff;
         as_im2_ff <= as_im1_ff;
         s_mre_ff  <= SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff);
         s_mim_ff  <= SUM_W'(p_ri_ff) + SUM_W'(p_ir_ff);
         s_dre_ff  <= SUM_W'(p_rr_ff) + SUM_W'(p_ii_ff);
         s_dim_ff  <= SUM_W'(p_ir_ff) - SUM_W'(p_ri_ff);
         den2_ff   <= PROD_W'($unsigned(d_r_ff)) + PROD_W'($unsigned(d_i_ff));
      end
   end

   always_comb begin
      sh_re   = s_mre_ff >>> FRAC_BITS;
      sh_im   = s_mim_ff >>> FRAC_BITS;
      mul_re  = sat_fn(SAT_W'(sh_re));
      mul_im  = sat_fn(SAT_W'(sh_im));
      neg_dre = -s_dre_ff;
      neg_dim = -s_dim_ff;
      mag_re3_in = s_dre_ff[SUM_W-1] ? neg_dre[PROD_W-1:0] : s_dre_ff[PROD_W-1:0];
      mag_im3_in = s_dim_ff[SUM_W-1] ? neg_dim[PROD_W-1:0] : s_dim_ff[PROD_W-1:0];
      meta3_in.func   = func2_ff;
      meta3_in.equal  = eq2_ff;
      meta3_in.dz     = dz2_ff;
      meta3_in.neg_re = s_dre_ff[SUM_W-1];
      meta3_in.neg_im = s_dim_ff[SUM_W-1];
      case (func2_ff)
         FUNC_ADD, FUNC_SUB: begin
            meta3_in.pre_ovf = as_re2_ff.ovf | as_im2_ff.ovf;
            meta3_in.pre_re  = as_re2_ff.val;
            meta3_in.pre_im  = as_im2_ff.val;
         end
         FUNC_MUL: begin
            meta3_in.pre_ovf = mul_re.ovf | mul_im.ovf;
            meta3_in.pre_re  = mul_re.val;
            meta3_in.pre_im  = mul_im.val;
         end
         default: begin
            meta3_in.pre_ovf = 1'b0;
            meta3_in.pre_re  = DATA_MAX;
            meta3_in.pre_im  = DATA_MAX;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         meta3_ff   <= meta3_in;
         mag_re3_ff <= mag_re3_in;
         mag_im3_ff <= mag_im3_in;
         den3_ff    <= den2_ff;
      end
   end

   assign out_valid  = valid_ff[2];
   assign out_meta   = meta3_ff;
   assign out_mag_re = mag_re3_ff;
   assign out_mag_im = mag_im3_ff;
   assign out_den    = den3_ff;
endmodule

@@ hw/rtl/cau_div.sv @@
`timescale 1ns / 1ps
module cau_div #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  cau_pkg::meta_type          in_meta,
   input  logic [cau_pkg::PROD_W-1:0] in_mag_re,
   input  logic [cau_pkg::PROD_W-1:0] in_mag_im,
   input  logic [cau_pkg::PROD_W-1:0] in_den,
   output logic                       out_valid,
   output cau_pkg::meta_type          out_meta,
   output logic [cau_pkg::QUOT_W-1:0] out_q_re,
   output logic [cau_pkg::QUOT_W-1:0] out_q_im,
   output logic                       out_qovf_re,
   output logic                       out_qovf_im
);
   import cau_pkg::*;

   localparam int NUM_W = PROD_W + FRAC_BITS;
   localparam int WIDE_W = PROD_W + QUOT_W;
   localparam int CMP_W = ((NUM_W > WIDE_W) ? NUM_W : WIDE_W) + 1;

   logic [NUM_W-1:0]  num_re, num_im;
   logic [CMP_W-1:0]  den_wide;

   logic              valid_ff [0:QUOT_W];
   meta_type          meta_ff  [0:QUOT_W];
   logic [PROD_W-1:0] den_ff   [0:QUOT_W];
   logic [REM_W-1:0]  rem_re_ff[0:QUOT_W];
   logic [REM_W-1:0]  rem_im_ff[0:QUOT_W];
   logic [QUOT_W-1:0] low_re_ff[0:QUOT_W];
   logic [QUOT_W-1:0] low_im_ff[0:QUOT_W];
   logic [QUOT_W-1:0] q_re_ff  [0:QUOT_W];
   logic [QUOT_W-1:0] q_im_ff  [0:QUOT_W];
   logic              ovf_re_ff[0:QUOT_W];
   logic              ovf_im_ff[0:QUOT_W];

   assign num_re   = NUM_W'(in_mag_re) << FRAC_BITS;
   assign num_im   = NUM_W'(in_mag_im) << FRAC_BITS;
   assign den_wide = CMP_W'(in_den) << QUOT_W;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         meta_ff[0]   <= in_meta;
         den_ff[0]    <= in_den;
         rem_re_ff[0] <= REM_W'(num_re >> QUOT_W);
         rem_im_ff[0] <= REM_W'(num_im >> QUOT_W);
         low_re_ff[0] <= num_re[QUOT_W-1:0];
         low_im_ff[0] <= num_im[QUOT_W-1:0];
         q_re_ff[0]   <= '0;
         q_im_ff[0]   <= '0;
         ovf_re_ff[0] <= CMP_W'(num_re) >= den_wide;
         ovf_im_ff[0] <= CMP_W'(num_im) >= den_wide;
      end
   end

   for (genvar k = 1; k <= QUOT_W; k++) begin : g_step
      logic [REM_W-1:0] t_re, t_im, d;
      logic             ge_re, ge_im;

      always_comb begin
         d     = REM_W'(den_ff[k-1]);
         t_re  = {rem_re_ff[k-1][REM_W-2:0], low_re_ff[k-1][QUOT_W-1]};
         t_im  = {rem_im_ff[k-1][REM_W-2:0], low_im_ff[k-1][QUOT_W-1]};
         ge_re = t_re >= d;
         ge_im = t_im >= d;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            meta_ff[k]   <= meta_ff[k-1];
            den_ff[k]    <= den_ff[k-1];
            rem_re_ff[k] <= ge_re ? (t_re - d) : t_re;
            rem_im_ff[k] <= ge_im ? (t_im - d) : t_im;
            low_re_ff[k] <= low_re_ff[k-1] << 1;
            low_im_ff[k] <= low_im_ff[k-1] << 1;
            q_re_ff[k]   <= {q_re_ff[k-1][QUOT_W-2:0], ge_re};
            q_im_ff[k]   <= {q_im_ff[k-1][QUOT_W-2:0], ge_im};
            ovf_re_ff[k] <= ovf_re_ff[k-1];
            ovf_im_ff[k] <= ovf_im_ff[k-1];
         end
      end
   end

   assign out_valid   = valid_ff[QUOT_W];
   assign out_meta    = meta_ff[QUOT_W];
   assign out_q_re    = q_re_ff[QUOT_W];
   assign out_q_im    = q_im_ff[QUOT_W];
   assign out_qovf_re = ovf_re_ff[QUOT_W];
   assign out_qovf_im = ovf_im_ff[QUOT_W];
endmodule

@@ hw/rtl/complex_arithmetic_unit.sv @@
// A request word passes through cau_prod, cau_div and the response register to its response word, for every operation.
// Throughput: one word per cycle while the pipeline is not stalled; the 32-stage restoring divider sets the depth.
// The whole pipeline holds while a response word waits and rsp_ch.ready is low.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_defines.svh"
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   cau_req_if.sink  req_ch,
   cau_rsp_if.source rsp_ch
);
   import cau_pkg::*;

   logic              pipe_enable;
   logic              prod_valid, div_valid;
   meta_type          prod_meta, div_meta;
   logic [PROD_W-1:0] mag_re, mag_im, den;
   logic [QUOT_W-1:0] q_re, q_im;
   logic              qovf_re, qovf_im;
   sat_type           dq_re, dq_im;
   logic              rsp_valid_ff;
   data_type          res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic              ovf_ff, ovf_in, dz_ff, eq_ff;

   function automatic sat_type quot_sat(input logic neg, input logic qovf,
                                        input logic [QUOT_W-1:0] q);
      sat_type r;
      if (!neg) begin
         r.ovf = qovf | q[QUOT_W-1];
         r.val = r.ovf ? DATA_MAX : data_type'(q);
      end else begin
         r.ovf = qovf | (q[QUOT_W-1] & (|q[QUOT_W-2:0]));
         r.val = r.ovf ? DATA_MIN : data_type'(-q);
      end
      return r;
   endfunction

   assign pipe_enable  = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = pipe_enable;

   cau_prod #(.FRAC_BITS(FRAC_BITS)) u_prod (
      .clock      (clock),
      .reset      (reset),
      .enable     (pipe_enable),
      .in_valid   (req_ch.valid),
      .in_func    (req_ch.func),
      .in_a_re    (req_ch.a_re),
      .in_a_im    (req_ch.a_im),
      .in_b_re    (req_ch.b_re),
      .in_b_im    (req_ch.b_im),
      .out_valid  (prod_valid),
      .out_meta   (prod_meta),
      .out_mag_re (mag_re),
      .out_mag_im (mag_im),
      .out_den    (den)
   );

   cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock       (clock),
      .reset       (reset),
      .enable      (pipe_enable),
      .in_valid    (prod_valid),
      .in_meta     (prod_meta),
      .in_mag_re   (mag_re),
      .in_mag_im   (mag_im),
      .in_den      (den),
      .out_valid   (div_valid),
      .out_meta    (div_meta),
      .out_q_re    (q_re),
      .out_q_im    (q_im),
      .out_qovf_re (qovf_re),
      .out_qovf_im (qovf_im)
   );

   always_comb begin
      dq_re = quot_sat(div_meta.neg_re, qovf_re, q_re);
      dq_im = quot_sat(div_meta.neg_im, qovf_im, q_im);
      if ((div_meta.func == FUNC_DIV) && !div_meta.dz) begin
         res_re_in = dq_re.val;
         res_im_in = dq_im.val;
         ovf_in    = dq_re.ovf | dq_im.ovf;
      end else begin
         res_re_in = div_meta.pre_re;
         res_im_in = div_meta.pre_im;
         ovf_in    = div_meta.pre_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         ovf_ff    <= ovf_in;
         dz_ff     <= div_meta.dz;
         eq_ff     <= div_meta.equal;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.res_re      = res_re_ff;
   assign rsp_ch.res_im      = res_im_ff;
   assign rsp_ch.overflow    = ovf_ff;
   assign rsp_ch.div_by_zero = dz_ff;
   assign rsp_ch.equal       = eq_ff;

   `CAU_ASSERT_IMP(a_dz_result, rsp_ch.valid && rsp_ch.div_by_zero,
      (rsp_ch.res_re == DATA_MAX) && (rsp_ch.res_im == DATA_MAX) && !rsp_ch.overflow,
      "divide by zero word carries wrong result")
   `CAU_ASSERT_IMP(a_ovf_saturated, rsp_ch.valid && rsp_ch.overflow,
      (rsp_ch.res_re == DATA_MAX) || (rsp_ch.res_re == DATA_MIN) ||
      (rsp_ch.res_im == DATA_MAX) || (rsp_ch.res_im == DATA_MIN),
      "overflow flagged without a saturated part")
   `CAU_ASSERT_NXT(a_stall_holds, !pipe_enable, $stable(div_valid) && $stable(div_meta),
      "pipeline moved during stall")
endmodule

@@ verif/complex_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps
module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      func_type func;
      data_type a_re;
      data_type a_im;
      data_type b_re;
      data_type b_im;
   } op_word_type;

   typedef struct {
      data_type res_re;
      data_type res_im;
      logic     overflow;
      logic     div_by_zero;
      logic     equal;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cau_req_if req_ch ();
   cau_rsp_if rsp_ch ();

   complex_arithmetic_unit #(.FRAC_BITS(FRAC)) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #5 clock = ~clock;

   op_word_type     pending_ops[$];
   result_word_type expected_results[$];
   int              mismatches = 0;
   int              results_seen = 0;
   int              ops_sent = 0;
   int              send_idle_pct = 11;
   int              recv_idle_pct = 68;
   int              idle_cycles = 0;
   bit              timed_out = 1'b0;
   int              func_count[4];

   function automatic data_type saturate(input logic signed [129:0] v, ref logic ovf);
      if (v > 130'sd2147483647) begin
         ovf = 1'b1;
         return DATA_MAX;
      end
      if (v < -130'sd2147483648) begin
         ovf = 1'b1;
         return DATA_MIN;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [129:0] div_trunc(input logic signed [129:0] num,
                                                    input logic signed [129:0] den);
      logic [129:0] q;
      logic         neg;
      neg = num[129];
      q = (neg ? -num : num) / den;
      return neg ? -$signed(q) : $signed(q);
   endfunction

   function automatic result_word_type complex_op(input op_word_type op);
      result_word_type r;
      logic signed [129:0] ar, ai, br, bi, sre, sim, den;
      logic ovf;
      ovf = 1'b0;
      ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
      r.div_by_zero = 1'b0;
      r.equal = (op.a_re == op.b_re) && (op.a_im == op.b_im);
      case (op.func)
         FUNC_ADD: begin
            sre = ar + br; sim = ai + bi;
         end
         FUNC_SUB: begin
            sre = ar - br; sim = ai - bi;
         end
         FUNC_MUL: begin
            sre = (ar * br - ai * bi) >>> FRAC;
            sim = (ar * bi + ai * br) >>> FRAC;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.div_by_zero = 1'b1;
            end else begin
               sre = div_trunc((ar * br + ai * bi) <<< FRAC, den);
               sim = div_trunc((ai * br - ar * bi) <<< FRAC, den);
            end
         end
      endcase
      if (r.div_by_zero) begin
         r.res_re = DATA_MAX;
         r.res_im = DATA_MAX;
      end else begin
         r.res_re = saturate(sre, ovf);
         r.res_im = saturate(sim, ovf);
      end
      r.overflow = ovf;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
   endtask

   function automatic data_type pick_value();
      case ($urandom_range(0, 9))
         0: return DATA_MAX;
         1: return DATA_MIN;
         2: return '0;
         3: return $signed($urandom_range(0, 8)) <<< FRAC;
         4: return -($signed($urandom_range(0, 8)) <<< FRAC);
         5: return $signed($urandom_range(0, 32'hFFFF)) - 32'sd32768;
         6: return $signed(32'($urandom_range(0, 32'h3FFFFF))) - 32'sd2097152;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_op(input func_type f, input data_type ar, input data_type ai,
                         input data_type br, input data_type bi);
      op_word_type op;
      op.func = f; op.a_re = ar; op.a_im = ai; op.b_re = br; op.b_im = bi;
      pending_ops.push_back(op);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(complex_op('{req_ch.func, req_ch.a_re, req_ch.a_im,
                                                   req_ch.b_re, req_ch.b_im}));
            ops_sent++;
            func_count[req_ch.func]++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               op_word_type op;
               op = pending_ops.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.func <= op.func;
               req_ch.a_re <= op.a_re;
               req_ch.a_im <= op.a_im;
               req_ch.b_re <= op.b_re;
               req_ch.b_im <= op.b_im;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_word_type want;
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected word", rsp_ch.res_re, 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.res_re !== want.res_re)
                  report_mismatch("res_re", rsp_ch.res_re, want.res_re);
               if (rsp_ch.res_im !== want.res_im)
                  report_mismatch("res_im", rsp_ch.res_im, want.res_im);
               if (rsp_ch.overflow !== want.overflow)
                  report_mismatch("overflow", 32'(rsp_ch.overflow), 32'(want.overflow));
               if (rsp_ch.div_by_zero !== want.div_by_zero)
                  report_mismatch("div_by_zero", 32'(rsp_ch.div_by_zero),
                                  32'(want.div_by_zero));
               if (rsp_ch.equal !== want.equal)
                  report_mismatch("equal", 32'(rsp_ch.equal), 32'(want.equal));
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results outstanding", expected_results.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_ADD;
      req_ch.a_re = '0;
      req_ch.a_im = '0;
      req_ch.b_re = '0;
      req_ch.b_im = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int f = 0; f < 4; f++) begin
         add_op(func_type'(f), DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
         add_op(func_type'(f), DATA_MIN, DATA_MIN, DATA_MAX, DATA_MIN);
         add_op(func_type'(f), 32'sh0001_8000, -32'sh0002_0000, 32'sh0001_8000,
                -32'sh0002_0000);
         add_op(func_type'(f), -32'sh0000_0001, 32'sh0003_0000, 32'sh0000_0001,
                32'sh0000_0000);
      end
      add_op(FUNC_DIV, 32'sh0001_0000, 32'sh0001_0000, '0, '0);
      add_op(FUNC_DIV, '0, '0, '0, '0);
      add_op(FUNC_DIV, DATA_MIN, DATA_MAX, 32'sh0000_0001, '0);
      add_op(FUNC_DIV, -32'sh0000_0007, 32'sh0000_0005, 32'sh0002_0000, -32'sh0003_0000);
      add_op(FUNC_MUL, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
      add_op(FUNC_MUL, -32'sh0000_0001, '0, 32'sh0000_0001, '0);
      add_op(FUNC_SUB, DATA_MIN, '0, 32'sh0000_0001, '0);
      add_op(FUNC_ADD, 32'sh1234_5678, 32'sh0000_0000, 32'sh1234_5678, 32'sh0000_0001);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 68 : 0;
         recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 11 : 0;
         for (int i = 0; i < 430; i++) begin
            data_type ar, ai, br, bi;
            ar = pick_value(); ai = pick_value(); br = pick_value(); bi = pick_value();
            if ($urandom_range(0, 15) == 0) begin
               br = ar; bi = ai;
            end
            if ($urandom_range(0, 30) == 0) begin
               br = '0; bi = '0;
            end
            add_op(func_type'($urandom_range(0, 3)), ar, ai, br, bi);
         end
         wait (pending_ops.size() == 0);
      end

      wait (!req_ch.valid && expected_results.size() == 0);
      repeat (60) @(posedge clock);
      $display("ran %0d operations: %0d add, %0d sub, %0d mul, %0d div; %0d results checked",
               ops_sent, func_count[0], func_count[1], func_count[2], func_count[3],
               results_seen);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
